### rtl/core/srsp_pkg.sv
package srsp_pkg;

  // Request opcodes
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_BUSY    = 3'd0,
    ST_READY   = 3'd1,
    ST_EOM     = 3'd2,
    ST_TIMEOUT = 3'd3,
    ST_IDLE    = 3'd4
  } status_t;

  // Field widths
  localparam int OP_W      = 2;
  localparam int BYTE_W    = 8;
  localparam int MAXC_W    = 11;
  localparam int TMO_W     = 16;
  localparam int STATUS_W  = 3;
  localparam int VALUE_W   = 32;
  localparam int INDEX_W   = 10;

  // Characters of interest
  localparam logic [BYTE_W-1:0] CH_EOM   = 8'd3;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'd10;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'd45;
  localparam logic [BYTE_W-1:0] CH_DOT   = 8'd46;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'd48;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'd57;

  // Parameter defaults
  localparam int DEF_MAX_BUFFER = 1024;
  localparam int DEF_TICK_BITS  = 16;

  // One result
  typedef struct packed {
    status_t              status;
    logic [VALUE_W-1:0]   reply_value;
    logic                 char_valid;
    logic [BYTE_W-1:0]    char_out;
    logic [INDEX_W-1:0]   char_index;
  } result_t;

endpackage

### rtl/core/srsp_if.sv
interface srsp_cmd_if
  import srsp_pkg::*;
();

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [BYTE_W-1:0]   data_byte;
  logic                string_mode;
  logic [MAXC_W-1:0]   max_chars;
  logic [TMO_W-1:0]    timeout_ticks;

  modport source (
    output valid, op, data_byte, string_mode, max_chars, timeout_ticks,
    input  ready
  );

  modport sink (
    input  valid, op, data_byte, string_mode, max_chars, timeout_ticks,
    output ready
  );
endinterface

interface srsp_rsp_if
  import srsp_pkg::*;
();

  logic                        valid;
  logic                        ready;
  logic [STATUS_W-1:0]         status;
  logic signed [VALUE_W-1:0]   reply_value;
  logic                        char_valid;
  logic [BYTE_W-1:0]           char_out;
  logic [INDEX_W-1:0]          char_index;

  modport source (
    output valid, status, reply_value, char_valid, char_out, char_index,
    input  ready
  );

  modport sink (
    input  valid, status, reply_value, char_valid, char_out, char_index,
    output ready
  );
endinterface

### rtl/core/serial_reply_status_parser.sv
// Channel | Dir | Payload                                               | Handshake
// --------+-----+-------------------------------------------------------+----------------
// cmd     | in  | op, data_byte, string_mode, max_chars, timeout_ticks   | valid & ready
// rsp     | out | status, reply_value, char_valid, char_out, char_index  | valid & ready
//
// Every request (start, byte, tick or unused opcode) yields exactly one response.
// The response is registered into the main output register, or the skid register
// behind a full main one; one request per cycle is sustained while the skid is empty.
// A two-entry output stage (main register plus skid register) decouples the
// sides: cmd.ready depends only on the skid register, never on rsp.ready.
// Reset (rst, synchronous) returns the parser to inactive and empties the output.
module serial_reply_status_parser
  import srsp_pkg::*;
#(
  parameter int MAX_BUFFER = DEF_MAX_BUFFER,
  parameter int TICK_BITS  = DEF_TICK_BITS
) (
  input  logic        clk,
  input  logic        rst,
  srsp_cmd_if.sink    cmd,
  srsp_rsp_if.source  rsp
);

  // Buffer size is bounded both by the parameter and by what max_chars can hold.
  localparam int MAXC_TOP = (1 << MAXC_W) - 1;
  localparam int CAP      = (MAX_BUFFER < MAXC_TOP) ? MAX_BUFFER : MAXC_TOP;
  localparam int LIM_W    = $clog2(CAP + 1);
  localparam int LIM_W1   = LIM_W + 1;
  localparam int CNT_W    = $clog2(CAP);
  localparam int TW       = (TICK_BITS < TMO_W) ? TICK_BITS : TMO_W;
  localparam int IDXX_W   = CNT_W + INDEX_W;

  // Parser state
  logic                 active;
  logic [BYTE_W-1:0]    previous_char;
  logic [VALUE_W-1:0]   accumulator;
  logic                 negative_seen;
  logic                 store_mode;
  logic [LIM_W-1:0]     buffer_limit;
  logic [CNT_W-1:0]     stored_count;
  logic [TW-1:0]        ticks_left;

  logic                 active_next;
  logic [BYTE_W-1:0]    previous_char_next;
  logic [VALUE_W-1:0]   accumulator_next;
  logic                 negative_seen_next;
  logic                 store_mode_next;
  logic [LIM_W-1:0]     buffer_limit_next;
  logic [CNT_W-1:0]     stored_count_next;
  logic [TW-1:0]        ticks_left_next;

  // Output stage
  result_t  out_main;
  result_t  out_skid;
  logic     out_valid;
  logic     skid_valid;
  result_t  res;

  logic accept;
  logic take;

  // Helpers
  logic [MAXC_W-1:0]   cap_val;
  logic [MAXC_W-1:0]   limit_sel;
  logic [LIM_W:0]      cnt_inc;
  logic                room;
  logic                is_digit;
  logic                after_eol;
  logic                seq_ready;
  logic                finish;
  logic [IDXX_W-1:0]   idx_ext;
  logic [VALUE_W-1:0]  acc_x10;

  assign cmd.ready = !skid_valid;
  assign accept    = cmd.valid && cmd.ready;
  assign take      = out_valid && rsp.ready;

  assign cap_val   = MAXC_W'(CAP);
  assign limit_sel = (cmd.max_chars < cap_val) ? cmd.max_chars : cap_val;
  assign cnt_inc   = LIM_W1'(stored_count) + 1'b1;
  assign room      = store_mode && (cnt_inc < {1'b0, buffer_limit});
  assign idx_ext   = IDXX_W'(stored_count);
  assign acc_x10   = (accumulator << 3) + (accumulator << 1);

  always_comb begin
    is_digit  = cmd.data_byte inside {[CH_ZERO:CH_NINE]};
    after_eol = previous_char inside {CH_CR, CH_LF};
    seq_ready = (cmd.data_byte == CH_DOT) && after_eol;
    finish    = seq_ready || (cmd.data_byte == CH_EOM);
  end

  // Next state and response for the request on cmd
  always_comb begin
    active_next        = active;
    previous_char_next = previous_char;
    accumulator_next   = accumulator;
    negative_seen_next = negative_seen;
    store_mode_next    = store_mode;
    buffer_limit_next  = buffer_limit;
    stored_count_next  = stored_count;
    ticks_left_next    = ticks_left;

    res.status      = active ? ST_BUSY : ST_IDLE;
    res.reply_value = '0;
    res.char_valid  = 1'b0;
    res.char_out    = '0;
    res.char_index  = '0;

    case (op_t'(cmd.op))
      OP_START: begin
        // Abandon any running reply and arm a new one.
        active_next        = 1'b1;
        previous_char_next = '0;
        accumulator_next   = '0;
        negative_seen_next = 1'b0;
        store_mode_next    = cmd.string_mode;
        buffer_limit_next  = limit_sel[LIM_W-1:0];
        stored_count_next  = '0;
        ticks_left_next    = cmd.timeout_ticks[TW-1:0];
        res.status         = ST_BUSY;
      end
      OP_TICK: begin
        if (active) begin
          // Count down; a count of one or zero expires on this tick.
          if (ticks_left <= TW'(1)) begin
            ticks_left_next = '0;
            active_next     = 1'b0;
            res.status      = ST_TIMEOUT;
          end else begin
            ticks_left_next = ticks_left - 1'b1;
          end
        end
      end
      OP_BYTE: begin
        if (active) begin
          if (room) begin
            res.char_valid    = 1'b1;
            res.char_out      = cmd.data_byte;
            res.char_index    = idx_ext[INDEX_W-1:0];
            stored_count_next = stored_count + 1'b1;
          end
          if (cmd.data_byte == CH_MINUS) begin
            negative_seen_next = 1'b1;
          end
          if (is_digit) begin
            accumulator_next = acc_x10 + VALUE_W'(cmd.data_byte - CH_ZERO);
          end
          previous_char_next = cmd.data_byte;
          if (finish) begin
            // Terminators are never digits, so the held accumulator is final.
            active_next = 1'b0;
            res.status  = seq_ready ? ST_READY : ST_EOM;
            if (!store_mode) begin
              res.reply_value = negative_seen ? (VALUE_W'(0) - accumulator) : accumulator;
            end
          end
        end
      end
      default: begin
        // Unused opcode: hold state, report busy or idle.
      end
    endcase
  end

  // Parser state registers: advance only on an accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= 1'b0;
      previous_char <= '0;
      accumulator   <= '0;
      negative_seen <= 1'b0;
      store_mode    <= 1'b0;
      buffer_limit  <= '0;
      stored_count  <= '0;
      ticks_left    <= '0;
    end else if (accept) begin
      active        <= active_next;
      previous_char <= previous_char_next;
      accumulator   <= accumulator_next;
      negative_seen <= negative_seen_next;
      store_mode    <= store_mode_next;
      buffer_limit  <= buffer_limit_next;
      stored_count  <= stored_count_next;
      ticks_left    <= ticks_left_next;
    end
  end

  // Output stage control: the skid entry catches a response when the main
  // register is full and not being drained.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (out_valid && !take) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  // Output stage payload
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        out_main <= out_skid;
      end
    end else if (accept) begin
      if (out_valid && !take) begin
        out_skid <= res;
      end else begin
        out_main <= res;
      end
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_main.status;
  assign rsp.reply_value = out_main.reply_value;
  assign rsp.char_valid  = out_main.char_valid;
  assign rsp.char_out    = out_main.char_out;
  assign rsp.char_index  = out_main.char_index;

  // The skid entry is only ever filled behind a full main register.
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry valid while main register empty");

  // A start request always leaves the parser active.
  a_start_arms: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.op == OP_START) |=> active)
    else $error("parser not active after start");

  // Stored characters come only in string mode, where the value is zero.
  a_char_no_value: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.char_valid) |-> (rsp.reply_value == '0))
    else $error("character stored alongside a numeric value");

  // The buffer index steps by at most one per request, or restarts.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (stored_count == $past(stored_count)) ||
                    (stored_count == $past(stored_count) + 1'b1) ||
                    (stored_count == '0))
    else $error("stored character count jumped");

endmodule

### tb/serial_reply_status_parser_tb.sv
`timescale 1ns / 1ps

module serial_reply_status_parser_tb;
  import srsp_pkg::*;

  // Receiver stall patterns, rotated at random so that stalls land on every
  // phase of a reply.
  typedef enum int {
    RX_STREAM,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_pattern_t;

  localparam int TOTAL_REQUESTS = 1850;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int FULL_BUFFER_BYTES = 1030;

  logic clk;
  logic rst;

  srsp_cmd_if cmd_bus ();
  srsp_rsp_if rsp_bus ();

  serial_reply_status_parser dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_bus),
    .rsp (rsp_bus)
  );

  // Predicted parser state, advanced once per accepted request.
  logic              parser_on;
  logic [BYTE_W-1:0] last_char;
  logic [31:0]       acc_value;
  logic              minus_seen;
  logic              keep_chars;
  logic [MAXC_W-1:0] buffer_size;
  logic [9:0]        chars_kept;
  logic [TMO_W-1:0]  ticks_remaining;

  // Responses predicted but not yet seen on the output, oldest first.
  result_t expected_replies[$];

  int error_count = 0;
  int requests_sent = 0;

  // Sender burst control.
  int burst_left = 0;
  bit back_to_back = 1'b0;

  // Receiver control: the long hold is counted down in the receiver process.
  bit long_hold_pending = 1'b0;
  int hold_left = 0;
  rx_pattern_t rx_pattern = RX_STREAM;
  int pattern_left = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Advance the predicted state by one request and return its response.
  function automatic result_t predict_response(input op_t op, input logic [BYTE_W-1:0] ch,
                                               input logic smode,
                                               input logic [MAXC_W-1:0] maxc,
                                               input logic [TMO_W-1:0] tmo);
    result_t r;
    int lim;
    logic seq_ready;
    r = '0;
    r.status = ST_BUSY;
    case (op)
      OP_START: begin
        // A start always rearms, abandoning any reply in progress.
        parser_on = 1'b1;
        last_char = '0;
        acc_value = '0;
        minus_seen = 1'b0;
        keep_chars = smode;
        buffer_size = maxc;
        chars_kept = '0;
        ticks_remaining = tmo;
      end
      OP_NONE: begin
        r.status = parser_on ? ST_BUSY : ST_IDLE;
      end
      OP_TICK: begin
        if (!parser_on) begin
          r.status = ST_IDLE;
        end else begin
          // Saturate at zero, so timeouts of 0 and 1 both expire on the first tick.
          if (ticks_remaining != 0) ticks_remaining--;
          if (ticks_remaining == 0) begin
            parser_on = 1'b0;
            r.status = ST_TIMEOUT;
          end
        end
      end
      default: begin
        if (!parser_on) begin
          r.status = ST_IDLE;
        end else begin
          // Keep the last buffer slot free.
          lim = (int'(buffer_size) < DEF_MAX_BUFFER) ? int'(buffer_size) : DEF_MAX_BUFFER;
          if (keep_chars && (int'(chars_kept) + 1 < lim)) begin
            r.char_valid = 1'b1;
            r.char_out = ch;
            r.char_index = chars_kept;
            chars_kept++;
          end
          if (ch == CH_MINUS) minus_seen = 1'b1;
          if (ch >= CH_ZERO && ch <= CH_NINE) begin
            acc_value = acc_value * 32'd10 + 32'(ch - CH_ZERO);
          end
          seq_ready = (ch == CH_DOT) && (last_char == CH_LF || last_char == CH_CR);
          last_char = ch;
          if (seq_ready || ch == CH_EOM) begin
            r.status = seq_ready ? ST_READY : ST_EOM;
            parser_on = 1'b0;
            if (!keep_chars) r.reply_value = minus_seen ? (32'd0 - acc_value) : acc_value;
          end
        end
      end
    endcase
    return r;
  endfunction

  // Drive one request and hold it until the parser takes it. Called at a
  // rising edge; returns at the edge where the request was accepted.
  task automatic send_request(input op_t op, input logic [BYTE_W-1:0] ch, input logic smode,
                              input logic [MAXC_W-1:0] maxc, input logic [TMO_W-1:0] tmo);
    int gap;
    if (!back_to_back && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        cmd_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    cmd_bus.valid <= 1'b1;
    cmd_bus.op <= op;
    cmd_bus.data_byte <= ch;
    cmd_bus.string_mode <= smode;
    cmd_bus.max_chars <= maxc;
    cmd_bus.timeout_ticks <= tmo;
    do @(posedge clk); while (!cmd_bus.ready);
    expected_replies.push_back(predict_response(op, ch, smode, maxc, tmo));
    requests_sent++;
  endtask

  // Unused fields carry random junk so that every bit toggles.
  task automatic send_start(input logic smode, input logic [MAXC_W-1:0] maxc,
                            input logic [TMO_W-1:0] tmo);
    send_request(OP_START, BYTE_W'($urandom_range(0, 255)), smode, maxc, tmo);
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] ch);
    send_request(OP_BYTE, ch, 1'($urandom_range(0, 1)), MAXC_W'($urandom_range(0, 2047)),
                 TMO_W'($urandom_range(0, 65535)));
  endtask

  task automatic send_tick();
    send_request(OP_TICK, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                 MAXC_W'($urandom_range(0, 2047)), TMO_W'($urandom_range(0, 65535)));
  endtask

  // Bias reply bytes toward digits and the characters that end a reply.
  function automatic logic [BYTE_W-1:0] pick_reply_char();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 8) return CH_ZERO + BYTE_W'($urandom_range(0, 9));
    if (pick == 8) return CH_MINUS;
    if (pick == 9) return CH_CR;
    if (pick == 10) return CH_LF;
    if (pick < 13) return CH_DOT;
    if (pick == 13) return CH_EOM;
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  // Idle and abandon cases, mode switches, the ready sequence after CR and
  // after LF, a lone dot, EOM kept in the buffer, and short timeouts.
  task automatic test_directed_cases();
    send_byte(8'hFF);                     // byte while idle
    send_request(OP_TICK, 8'h00, 1'b0, '0, '0);
    send_request(OP_NONE, 8'h00, 1'b0, '0, '0);
    send_start(1'b0, 11'd0, 16'd0);
    send_tick();                          // zero timeout expires at once
    send_start(1'b1, 11'd3, 16'hFFFF);
    send_byte(CH_MINUS);
    send_byte(CH_ZERO + 8'd4);
    send_byte(CH_ZERO + 8'd2);            // buffer full, not stored
    send_request(OP_NONE, 8'hFF, 1'b1, 11'h7FF, 16'hFFFF);
    send_start(1'b0, 11'd2047, 16'd1);    // abandon the running reply
    send_byte(CH_MINUS);
    send_byte(CH_ZERO + 8'd7);
    send_byte(CH_CR);
    send_byte(CH_DOT);                    // ready sequence, value -7
    send_start(1'b1, 11'd1, 16'd2);
    send_byte(CH_EOM);                    // size 1 stores nothing
    send_start(1'b1, 11'd1024, 16'd2);
    send_tick();
    send_byte(CH_DOT);                    // dot with no CR/LF before it
    send_byte(CH_EOM);                    // EOM stored, then the reply ends
    send_start(1'b0, 11'd0, 16'd1);
    send_byte(CH_LF);
    send_byte(CH_DOT);
  endtask

  // Fill the buffer on one long string reply, so the index runs from 0 to 1022.
  task automatic test_full_buffer();
    logic [BYTE_W-1:0] ch;
    send_start(1'b1, MAXC_W'($urandom_range(1024, 2047)), 16'hFFFF);
    repeat (FULL_BUFFER_BYTES) begin
      ch = BYTE_W'($urandom_range(0, 255));
      if (ch == CH_EOM || ch == CH_DOT) ch = ~ch;
      send_byte(ch);
    end
    send_byte(CH_EOM);
  endtask

  // Hold the receiver off while requests keep coming, so the output stage
  // fills and the parser stalls its input.
  task automatic test_backpressure();
    back_to_back = 1'b1;
    long_hold_pending = 1'b1;
    send_start(1'b1, 11'd40, 16'hFFFF);
    repeat (60) send_byte(pick_reply_char());
    back_to_back = 1'b0;
  endtask

  // Mostly well-formed replies with random content, some cut by timeout or
  // by a new start, with stray requests in between.
  task automatic test_random_replies();
    int sel;
    int len;
    logic [MAXC_W-1:0] maxc;
    logic [TMO_W-1:0] tmo;
    while (requests_sent < TOTAL_REQUESTS) begin
      sel = $urandom_range(0, 9);
      if (sel < 7) maxc = MAXC_W'($urandom_range(0, 16));
      else if (sel < 9) maxc = MAXC_W'($urandom_range(0, 2047));
      else maxc = $urandom_range(0, 1) ? 11'd1024 : 11'd2047;
      sel = $urandom_range(0, 9);
      if (sel < 5) tmo = TMO_W'($urandom_range(0, 6));
      else if (sel < 9) tmo = TMO_W'($urandom_range(7, 60));
      else tmo = TMO_W'($urandom_range(0, 65535));
      send_start(1'($urandom_range(0, 1)), maxc, tmo);
      len = $urandom_range(0, 24);
      repeat (len) begin
        if ($urandom_range(0, 7) == 0) send_tick();
        else send_byte(pick_reply_char());
      end
      sel = $urandom_range(0, 9);
      if (sel < 4) begin
        send_byte(CH_EOM);
      end else if (sel < 8) begin
        send_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
        send_byte(CH_DOT);
      end
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          send_request(op_t'($urandom_range(1, 3)), BYTE_W'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)), MAXC_W'($urandom_range(0, 2047)),
                       TMO_W'($urandom_range(0, 65535)));
        end
      end
    end
  endtask

  // Receiver: a long hold when asked for, else a rotating stall pattern.
  always @(posedge clk) begin
    if (long_hold_pending) begin
      hold_left = LONG_HOLD_CYCLES;
      long_hold_pending = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_bus.ready <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        rx_pattern = rx_pattern_t'($urandom_range(0, 3));
        pattern_left = $urandom_range(20, 150);
      end
      pattern_left--;
      case (rx_pattern)
        RX_STREAM:   rsp_bus.ready <= 1'b1;
        RX_COIN:     rsp_bus.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE:   rsp_bus.ready <= ($urandom_range(0, 3) == 0);
        default:     rsp_bus.ready <= (pattern_left % 8) < 5;
      endcase
    end
  end

  // Compare each accepted response with the oldest prediction.
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (expected_replies.size() == 0) begin
        $error("response with no request outstanding: status %0d", rsp_bus.status);
        error_count++;
      end else begin
        exp_r = expected_replies.pop_front();
        if (rsp_bus.status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, rsp_bus.status);
          error_count++;
        end
        if (rsp_bus.reply_value !== exp_r.reply_value) begin
          $error("reply_value: expected %0d, got %0d", $signed(exp_r.reply_value),
                 rsp_bus.reply_value);
          error_count++;
        end
        if (rsp_bus.char_valid !== exp_r.char_valid) begin
          $error("char_valid: expected %0d, got %0d", exp_r.char_valid, rsp_bus.char_valid);
          error_count++;
        end
        if (rsp_bus.char_out !== exp_r.char_out) begin
          $error("char_out: expected %0d, got %0d", exp_r.char_out, rsp_bus.char_out);
          error_count++;
        end
        if (rsp_bus.char_index !== exp_r.char_index) begin
          $error("char_index: expected %0d, got %0d", exp_r.char_index, rsp_bus.char_index);
          error_count++;
        end
      end
    end
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst = 1'b1;
    cmd_bus.valid = 1'b0;
    cmd_bus.op = OP_NONE;
    cmd_bus.data_byte = '0;
    cmd_bus.string_mode = 1'b0;
    cmd_bus.max_chars = '0;
    cmd_bus.timeout_ticks = '0;
    parser_on = 1'b0;
    last_char = '0;
    acc_value = '0;
    minus_seen = 1'b0;
    keep_chars = 1'b0;
    buffer_size = '0;
    chars_kept = '0;
    ticks_remaining = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_full_buffer();
    test_backpressure();
    test_random_replies();

    // Drop valid, drain what is still in flight, then let the output settle.
    cmd_bus.valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
